/* rtl/core/lru_pr_pkg.sv */
// Shared definitions for the LRU page replacement frame table.
// Holds the frame update operation codes and the fixed port widths.
// No dependencies.
`default_nettype none

package lru_pr_pkg;

  localparam int PAGE_W  = 16;
  localparam int SLOT_W  = 3;
  localparam int TOTAL_W = 16;
  localparam int CFG_W   = 4;

  localparam logic [CFG_W-1:0] FRAMES_IN_USE_RESET = 4'd4;

  // Operation broadcast to every frame cell in the update cycle.
  typedef enum logic [2:0] {
    UPD_NONE,
    UPD_HIT,
    UPD_FILL,
    UPD_REPLACE,
    UPD_CLEAR
  } upd_op_t;

endpackage

`default_nettype wire

/* rtl/core/lru_pr_cell.sv */
// One frame cell of the LRU frame table: page, valid flag and recency rank.
// Folds its frame into the scan record handed on to the next cell.
// Depends on lru_pr_pkg.
`default_nettype none

module lru_pr_cell #(
  parameter int  INDEX    = 0,
  parameter int  IDX_BITS = 3,
  parameter int  PG_BITS  = 16,
  parameter type scan_t   = logic,
  parameter type upd_t    = logic
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [PG_BITS-1:0] pg,
  input  scan_t              scan_in,
  input  upd_t               upd,
  output scan_t              scan_out
);

  logic [PG_BITS-1:0]  page_r;
  logic                valid;
  logic [IDX_BITS-1:0] rank;
  scan_t               scan_next;
  logic                is_self;
  logic                ages;

  always_comb begin
    scan_next = scan_in;
    if (valid) begin
      scan_next.used = scan_in.used + $bits(scan_in.used)'(1);
    end
    if (!scan_in.hit_found && valid && (page_r == pg)) begin
      scan_next.hit_found = 1'b1;
      scan_next.hit_idx   = IDX_BITS'(INDEX);
      scan_next.hit_rank  = rank;
    end
    if (!scan_in.empty_found && !valid) begin
      scan_next.empty_found = 1'b1;
      scan_next.empty_idx   = IDX_BITS'(INDEX);
    end
    // Strictly greater keeps the lowest index on a tie.
    if (valid && (!scan_in.lru_found || (rank > scan_in.lru_rank))) begin
      scan_next.lru_found = 1'b1;
      scan_next.lru_idx   = IDX_BITS'(INDEX);
      scan_next.lru_rank  = rank;
      scan_next.lru_page  = page_r;
    end
  end

  always_ff @(posedge clk) begin
    scan_out <= scan_next;
  end

  assign is_self = (upd.slot == IDX_BITS'(INDEX));
  assign ages = valid && !is_self &&
                ((upd.op == lru_pr_pkg::UPD_FILL) ||
                 (((upd.op == lru_pr_pkg::UPD_HIT) || (upd.op == lru_pr_pkg::UPD_REPLACE)) &&
                  (rank < upd.limit_rank)));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
    end else begin
      case (upd.op)
        lru_pr_pkg::UPD_CLEAR: begin
          valid <= 1'b0;
          rank  <= '0;
        end
        lru_pr_pkg::UPD_HIT, lru_pr_pkg::UPD_FILL, lru_pr_pkg::UPD_REPLACE: begin
          if (is_self) begin
            rank <= '0;
            if (upd.op != lru_pr_pkg::UPD_HIT) begin
              valid <= 1'b1;
            end
          end else if (ages) begin
            rank <= rank + IDX_BITS'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (is_self && ((upd.op == lru_pr_pkg::UPD_FILL) || (upd.op == lru_pr_pkg::UPD_REPLACE))) begin
      page_r <= pg;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lru_page_replacement.sv */
// Top level of the fully associative LRU page frame table.
// Chains FRAMES lru_pr_cell instances and sequences scan and update; uses lru_pr_pkg.
//
//   channel   handshake              payload
//   request   start & !busy          page, last_reference
//   result    done (one cycle)       hit, frame_slot, evicted_valid, evicted_page,
//                                    hit_total, miss_total
//   config    cfg_valid & cfg_ready  cfg_data (frames_in_use)
//
// From accept to result, the page is first loaded into a register, then the scan record
// travels the registered chain of FRAMES cells, and last an update is broadcast to all
// cells at once. busy stays high over that span and
// drops in the cycle in which done is shown. Reset is synchronous and leaves the table
// empty at once, with no clearing pass. The receiver cannot stall results.
`default_nettype none

module lru_page_replacement #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [lru_pr_pkg::PAGE_W-1:0]      page,
  input  logic                               last_reference,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lru_pr_pkg::CFG_W-1:0]       cfg_data,
  output logic                               done,
  output logic                               hit,
  output logic [lru_pr_pkg::SLOT_W-1:0]      frame_slot,
  output logic                               evicted_valid,
  output logic [lru_pr_pkg::PAGE_W-1:0]      evicted_page,
  output logic [lru_pr_pkg::TOTAL_W-1:0]     hit_total,
  output logic [lru_pr_pkg::TOTAL_W-1:0]     miss_total
);

  localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW = $clog2(FRAMES + 1);
  localparam int SB = (PAGE_BITS < lru_pr_pkg::PAGE_W) ? PAGE_BITS : lru_pr_pkg::PAGE_W;

  typedef struct packed {
    logic          hit_found;
    logic [IW-1:0] hit_idx;
    logic [IW-1:0] hit_rank;
    logic [CW-1:0] used;
    logic          empty_found;
    logic [IW-1:0] empty_idx;
    logic          lru_found;
    logic [IW-1:0] lru_idx;
    logic [IW-1:0] lru_rank;
    logic [SB-1:0] lru_page;
  } scan_t;

  typedef struct packed {
    lru_pr_pkg::upd_op_t op;
    logic [IW-1:0]       slot;
    logic [IW-1:0]       limit_rank;
  } upd_t;

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    UPDATE
  } state_t;

  state_t                          state;
  logic [IW-1:0]                   scan_cnt;
  logic [SB-1:0]                   pg_q;
  logic                            last_q;
  logic [lru_pr_pkg::CFG_W-1:0]    frames_in_use;
  logic [lru_pr_pkg::TOTAL_W-1:0]  hit_counter;
  logic [lru_pr_pkg::TOTAL_W-1:0]  miss_counter;
  logic [lru_pr_pkg::TOTAL_W-1:0]  hit_counter_next;
  logic [lru_pr_pkg::TOTAL_W-1:0]  miss_counter_next;
  logic [CW-1:0]                   limit;
  scan_t                           chain [FRAMES+1];
  scan_t                           scan_res;
  upd_t                            upd;
  logic                            dec_hit;
  logic                            dec_evict;

  // The limit may only change between references, and a request in the same cycle goes first.
  assign cfg_ready = !busy && !start;
  assign busy      = (state != IDLE);
  assign chain[0]  = '0;
  assign scan_res  = chain[FRAMES];

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= lru_pr_pkg::FRAMES_IN_USE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      frames_in_use <= cfg_data;
    end
  end

  // A limit of zero acts as one, a limit above the table size as the table size.
  always_comb begin
    if (frames_in_use == '0) begin
      limit = CW'(1);
    end else if (32'(frames_in_use) > FRAMES) begin
      limit = CW'(FRAMES);
    end else begin
      limit = CW'(frames_in_use);
    end
  end

  always_comb begin
    dec_hit        = 1'b0;
    dec_evict      = 1'b0;
    upd.op         = lru_pr_pkg::UPD_NONE;
    upd.slot       = scan_res.lru_idx;
    upd.limit_rank = scan_res.lru_rank;
    if (state == UPDATE) begin
      if (scan_res.hit_found) begin
        dec_hit        = 1'b1;
        upd.op         = lru_pr_pkg::UPD_HIT;
        upd.slot       = scan_res.hit_idx;
        upd.limit_rank = scan_res.hit_rank;
      end else if ((scan_res.used < limit) && scan_res.empty_found) begin
        upd.op   = lru_pr_pkg::UPD_FILL;
        upd.slot = scan_res.empty_idx;
      end else begin
        dec_evict = 1'b1;
        upd.op    = lru_pr_pkg::UPD_REPLACE;
      end
      // The last reference of a string empties the table after its result.
      if (last_q) begin
        upd.op = lru_pr_pkg::UPD_CLEAR;
      end
    end
  end

  assign hit_counter_next  = (dec_hit && (hit_counter != '1)) ?
                             hit_counter + lru_pr_pkg::TOTAL_W'(1) : hit_counter;
  assign miss_counter_next = (!dec_hit && (miss_counter != '1)) ?
                             miss_counter + lru_pr_pkg::TOTAL_W'(1) : miss_counter;

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    lru_pr_cell #(
      .INDEX    (i),
      .IDX_BITS (IW),
      .PG_BITS  (SB),
      .scan_t   (scan_t),
      .upd_t    (upd_t)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .pg       (pg_q),
      .scan_in  (chain[i]),
      .upd      (upd),
      .scan_out (chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      scan_cnt     <= '0;
      done         <= 1'b0;
      hit_counter  <= '0;
      miss_counter <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        IDLE: begin
          if (start) begin
            pg_q     <= page[SB-1:0];
            last_q   <= last_reference;
            scan_cnt <= '0;
            state    <= SCAN;
          end
        end
        SCAN: begin
          if (scan_cnt == IW'(FRAMES - 1)) begin
            state <= UPDATE;
          end else begin
            scan_cnt <= scan_cnt + IW'(1);
          end
        end
        UPDATE: begin
          done          <= 1'b1;
          hit           <= dec_hit;
          frame_slot    <= lru_pr_pkg::SLOT_W'(upd.slot);
          evicted_valid <= dec_evict;
          evicted_page  <= dec_evict ? lru_pr_pkg::PAGE_W'(scan_res.lru_page) : '0;
          hit_total     <= hit_counter_next;
          miss_total    <= miss_counter_next;
          if (last_q) begin
            hit_counter  <= '0;
            miss_counter <= '0;
          end else begin
            hit_counter  <= hit_counter_next;
            miss_counter <= miss_counter_next;
          end
          state <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_done_after_update: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == UPDATE))
    else $error("result strobe without an update cycle");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted reference did not start a scan");

  a_evict_is_miss: assert property (@(posedge clk) disable iff (rst)
    (done && evicted_valid) |-> (!hit && (miss_total != '0)))
    else $error("eviction reported on a hit");

  a_hit_counted: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> (hit_total != '0))
    else $error("hit reported with a zero hit total");

  a_replace_has_victim: assert property (@(posedge clk) disable iff (rst)
    (state == UPDATE && dec_evict) |-> scan_res.lru_found)
    else $error("replacement without a valid frame");

endmodule

`default_nettype wire
